// ----- sv/fifo_ready_queue_with_removal_macros.svh -----
// assertion macros used by the ready queue sequencer
`ifndef FIFO_READY_QUEUE_WITH_REMOVAL_MACROS_SVH
`define FIFO_READY_QUEUE_WITH_REMOVAL_MACROS_SVH

// checked on every rising edge outside reset
`define FRQR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define FRQR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/frqr_pkg.sv -----
// shared types and constants of the ready queue
package frqr_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_YIELD = 2'd1,
    REQ_TERM  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_CMP,
    S_SRD,
    S_SWR,
    S_DONE
  } state_t;

  // memory port strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // result flags handed to the output register
  typedef struct packed {
    logic    dvalid;
    status_t status;
  } res_flags_t;

endpackage

// ----- sv/frqr_store.sv -----
// identifier store: one write port, one registered read port
module frqr_store
  import frqr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  localparam int IDX_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic               clk,
  input  mem_ctl_t           ctl,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [ID_BITS-1:0] wr_data,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [ID_BITS-1:0] rd_data
);

  logic [ID_BITS-1:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/frqr_ctrl.sv -----
// request sequencer: scan with a shared compare, then compact one entry at a time
`include "fifo_ready_queue_with_removal_macros.svh"

module frqr_ctrl
  import frqr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  localparam int IDX_W      = $clog2(QUEUE_DEPTH),
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  req_t               in_req,
  input  logic [ID_BITS-1:0] in_id,
  output logic               res_valid,
  input  logic               res_ready,
  output res_flags_t         res_flags,
  output logic [ID_BITS-1:0] res_id,
  output logic [CNT_W-1:0]   res_count,
  output mem_ctl_t           mem_ctl,
  output logic [IDX_W-1:0]   wr_addr,
  output logic [ID_BITS-1:0] wr_data,
  output logic [IDX_W-1:0]   rd_addr,
  input  logic [ID_BITS-1:0] rd_data
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  state_t             state;
  state_t             state_next;
  req_t               req;
  logic [ID_BITS-1:0] tid;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   idx_inc;
  logic               idx_more;
  logic               hit;
  logic               dvalid;
  logic [ID_BITS-1:0] disp;
  status_t            status;

  // shared step unit: next position and whether it is still inside the queue
  assign idx_inc  = idx + CNT_W'(1);
  assign idx_more = (idx_inc < cnt);
  assign hit      = (req == REQ_YIELD) || (rd_data == tid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        unique case (req)
          REQ_YIELD, REQ_TERM: state_next = (cnt == '0) ? S_DONE : S_RD;
          REQ_ADD, REQ_NONE:   state_next = S_DONE;
        endcase
      end
      S_RD: state_next = S_CMP;
      S_CMP: begin
        if (hit) begin
          state_next = S_SRD;
        end else if (idx_more) begin
          state_next = S_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SRD: state_next = idx_more ? S_SWR : S_DONE;
      S_SWR: state_next = S_SRD;
      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    res_valid     = (state == S_DONE);
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    wr_addr       = idx[IDX_W-1:0];
    wr_data       = rd_data;
    rd_addr       = idx[IDX_W-1:0];
    unique case (state)
      S_START: begin
        mem_ctl.wr_en = (req == REQ_ADD) && (cnt != DEPTH_C);
        wr_addr       = cnt[IDX_W-1:0];
        wr_data       = tid;
      end
      S_RD: mem_ctl.rd_en = 1'b1;
      S_SRD: begin
        // pull the follower of the gap
        mem_ctl.rd_en = idx_more;
        rd_addr       = idx_inc[IDX_W-1:0];
      end
      S_SWR: mem_ctl.wr_en = 1'b1;
      S_IDLE, S_CMP, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      unique case (state)
        S_START: begin
          if ((req == REQ_ADD) && (cnt != DEPTH_C)) cnt <= cnt + CNT_W'(1);
        end
        S_SRD: begin
          if (!idx_more) cnt <= cnt - CNT_W'(1);
        end
        S_IDLE, S_RD, S_CMP, S_SWR, S_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req    <= in_req;
          tid    <= in_id;
          idx    <= '0;
          dvalid <= 1'b0;
          disp   <= '0;
          status <= ST_OK;
        end
      end
      S_START: begin
        unique case (req)
          REQ_ADD:   if (cnt == DEPTH_C) status <= ST_FULL;
          REQ_YIELD: if (cnt == '0) status <= ST_EMPTY;
          REQ_TERM:  if (cnt == '0) status <= ST_NOTFOUND;
          REQ_NONE:  status <= ST_OK;
        endcase
      end
      S_CMP: begin
        if (hit) begin
          if (req == REQ_YIELD) begin
            dvalid <= 1'b1;
            disp   <= rd_data;
          end
        end else if (idx_more) begin
          idx <= idx_inc;
        end else begin
          status <= ST_NOTFOUND;
        end
      end
      S_SWR: idx <= idx_inc;
      S_RD, S_SRD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign res_flags.dvalid = dvalid;
  assign res_flags.status = status;
  assign res_id           = disp;
  assign res_count        = cnt;

  `FRQR_ASSERT_ALWAYS(a_rst_clears, rst |=> (cnt == '0) && (state == S_IDLE), "reset did not clear the queue")
  `FRQR_ASSERT(a_cnt_bound, cnt <= DEPTH_C, "entry count above queue depth")
  `FRQR_ASSERT(a_wr_in_range, mem_ctl.wr_en |-> (CNT_W'(wr_addr) < cnt) || (state == S_START), "write outside held entries")
  `FRQR_ASSERT(a_cnt_step, !$past(rst) && !$stable(cnt) |-> ($past(state) == S_START) || ($past(state) == S_SRD), "count changed outside add or removal")
  `FRQR_ASSERT(a_dispatch_yield, res_valid && res_flags.dvalid |-> (req == REQ_YIELD) && (status == ST_OK), "dispatch without a yield")
  `FRQR_ASSERT(a_notfound_term, res_valid && (res_flags.status == ST_NOTFOUND) |-> req == REQ_TERM, "not found on a request other than terminate")

endmodule

// ----- sv/fifo_ready_queue_with_removal.sv -----
// top level of the ready queue: request capture, sequencer, store and result register
//
//   channel  dir  tdata                               tuser
//   s_*      in   thread_id                           req_type
//   m_*      out  dispatch_id, queue_count            dispatch_valid, status
//
// add, unused codes and requests on an empty queue pass from the start state straight to the result
// yield and terminate read one entry at a time through the single read port of the store:
//   each scanned position passes a read and a compare state, and a miss ends at the last
//   compare; after a hit at p each of the n-1-p followers takes a read and a write state
// reset clears the count and the sequencer; the store needs no clearing pass
// a finished result waits in the output register while the next request is taken
module fifo_ready_queue_with_removal
  import frqr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  localparam int IDX_W      = $clog2(QUEUE_DEPTH),
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int S_DATA_W   = ((ID_BITS + 7) / 8) * 8,
  localparam int M_DATA_W   = ((ID_BITS + CNT_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // thread_id
  input  logic [1:0]          s_tuser,  // req_type
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // dispatch_id, queue_count
  output logic [2:0]          m_tuser   // dispatch_valid, status
);

  logic               res_valid;
  logic               res_ready;
  res_flags_t         res_flags;
  logic [ID_BITS-1:0] res_id;
  logic [CNT_W-1:0]   res_count;
  mem_ctl_t           mem_ctl;
  logic [IDX_W-1:0]   wr_addr;
  logic [ID_BITS-1:0] wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [ID_BITS-1:0] rd_data;

  logic               out_valid;
  res_flags_t         out_flags;
  logic [ID_BITS-1:0] out_id;
  logic [CNT_W-1:0]   out_count;

  frqr_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_req   (req_t'(s_tuser)),
    .in_id    (s_tdata[ID_BITS-1:0]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_flags(res_flags),
    .res_id   (res_id),
    .res_count(res_count),
    .mem_ctl  (mem_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  frqr_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_store (
    .clk    (clk),
    .ctl    (mem_ctl),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // result register frees up in the same cycle it is taken
  assign res_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_flags <= res_flags;
      out_id    <= res_id;
      out_count <= res_count;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_DATA_W'({out_count, out_id});
  assign m_tuser  = {out_flags.status, out_flags.dvalid};

endmodule
